FILE: src/lpt_pkg.sv
// Shared types and constants for the LCD page transpose feeder.
package lpt_pkg;

  // Position counter and strip memory geometry
  localparam int COL_W       = 4;
  localparam int ROW_W       = 6;
  localparam int PAGE_W      = 3;
  localparam int STRIP_DEPTH = 16;
  localparam int STRIP_LANES = 7;
  localparam int STRIP_W     = 8 * STRIP_LANES;

  // Panel commands
  localparam logic [7:0] CMD_COL_RESET = 8'h40;
  localparam logic [7:0] CMD_PAGE      = 8'hB8;

  // Strip row whose byte completes a column
  localparam logic [2:0] LAST_STRIP_ROW = 3'd7;

  // Emitter sequence steps: column-reset pair, page command, 8 data bytes
  localparam logic [3:0] STEP_PAIR_L    = 4'd0;
  localparam logic [3:0] STEP_PAIR_R    = 4'd1;
  localparam logic [3:0] STEP_PAGE      = 4'd2;
  localparam logic [3:0] STEP_DATA0     = 4'd3;
  localparam logic [3:0] STEP_DATA_LAST = 4'd10;

  // Position of the current item
  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [2:0]        strip_row;
    logic [PAGE_W-1:0] page;
    logic              half;
    logic              page_en;
    logic              pair;
  } pos_t;

  // Work handed to the emitter
  typedef struct packed {
    logic              half;
    logic              page_en;
    logic              pair;
    logic [PAGE_W-1:0] page;
    logic [7:0]        pix;
  } job_t;

  // Bit transpose of an 8x8 block: out byte b, bit k = in byte k, bit b
  function automatic logic [63:0] transpose8(input logic [63:0] blk);
    logic [63:0] t;
    t = '0;
    for (int b = 0; b < 8; b++) begin
      for (int k = 0; k < 8; k++) begin
        t[b*8 + k] = blk[k*8 + b];
      end
    end
    return t;
  endfunction

endpackage

FILE: src/lcd_page_transpose_feeder.sv
// Top level of the LCD page transpose feeder.
// An accepted item passes through the job slot and the sequencer into the output register.
// Throughput: one result per cycle on the single output port while out_stall
// is low; an item holds the sequencer for all the results it causes (2 at the
// top-left position, 8 or 9 on strip row 7), items without results bypass it.
// Reset: position counters and valid bits clear; the strip memory is not cleared.
module lcd_page_transpose_feeder #(
  parameter int SCREEN_ROWS   = 64,
  parameter int BYTES_PER_ROW = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_pixel_byte,
  input  logic       in_frame_start,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_half_select,
  output logic       out_is_data,
  output logic [7:0] out_bus_byte,
  output logic       out_run_last
);

  logic                         accept;
  logic                         job_ready;
  logic                         row7;
  lpt_pkg::pos_t                pos;
  lpt_pkg::job_t                job;
  logic [lpt_pkg::STRIP_W-1:0]  rd_data;

  assign in_stall = !job_ready;
  assign accept   = in_valid && job_ready;
  assign row7     = (pos.strip_row == lpt_pkg::LAST_STRIP_ROW);

  lpt_locator #(
    .SCREEN_ROWS   (SCREEN_ROWS),
    .BYTES_PER_ROW (BYTES_PER_ROW)
  ) u_locator (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (accept),
    .frame_start (in_frame_start),
    .pos         (pos)
  );

  // Strip rows 0-6 are stored, row 7 reads the column back
  lpt_strip_mem u_mem (
    .clk     (clk),
    .wr_en   (accept && !row7),
    .wr_addr (pos.col),
    .wr_lane (pos.strip_row),
    .wr_data (in_pixel_byte),
    .rd_en   (accept && row7),
    .rd_addr (pos.col),
    .rd_data (rd_data)
  );

  // Job for the sequencer
  always_comb begin
    job.half    = pos.half;
    job.page_en = pos.page_en && row7;
    job.pair    = pos.pair;
    job.page    = pos.page;
    job.pix     = in_pixel_byte;
  end

  lpt_emitter u_emitter (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (accept && (pos.pair || row7)),
    .job             (job),
    .job_ready       (job_ready),
    .rd_data         (rd_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_half_select (out_half_select),
    .out_is_data     (out_is_data),
    .out_bus_byte    (out_bus_byte),
    .out_run_last    (out_run_last)
  );

endmodule

FILE: src/lpt_strip_mem.sv
// Per-column strip memory: byte-lane writes, registered 56-bit reads.
module lpt_strip_mem (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [lpt_pkg::COL_W-1:0]            wr_addr,
  input  logic [2:0]                           wr_lane,
  input  logic [7:0]                           wr_data,
  input  logic                                 rd_en,
  input  logic [lpt_pkg::COL_W-1:0]            rd_addr,
  output logic [lpt_pkg::STRIP_W-1:0]          rd_data
);

  logic [lpt_pkg::STRIP_W-1:0] mem [lpt_pkg::STRIP_DEPTH];
  logic [lpt_pkg::STRIP_W-1:0] rd_data_r;

  // Write one strip row of a column
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr][{wr_lane, 3'b000} +: 8] <= wr_data;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/lpt_locator.sv
// Row and column position counters with wrap and frame restart.
module lpt_locator #(
  parameter int SCREEN_ROWS   = 64,
  parameter int BYTES_PER_ROW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          advance,
  input  logic          frame_start,
  output lpt_pkg::pos_t pos
);

  logic [lpt_pkg::COL_W-1:0] col_r, col_nxt, cur_col;
  logic [lpt_pkg::ROW_W-1:0] row_r, row_nxt, cur_row;
  logic [lpt_pkg::COL_W:0]   col_inc;
  logic [lpt_pkg::ROW_W:0]   row_inc;

  // Position used by this item
  always_comb begin
    cur_col = frame_start ? '0 : col_r;
    cur_row = frame_start ? '0 : row_r;
    pos.col       = cur_col;
    pos.strip_row = cur_row[2:0];
    pos.page      = cur_row[lpt_pkg::ROW_W-1:3];
    pos.half      = (cur_col >= lpt_pkg::COL_W'(BYTES_PER_ROW / 2));
    pos.page_en   = (cur_col == '0) || (cur_col == lpt_pkg::COL_W'(BYTES_PER_ROW / 2));
    pos.pair      = (cur_col == '0) && (cur_row == '0);
  end

  // Advance with wrap at row end and frame end
  always_comb begin
    col_inc = {1'b0, cur_col} + 1'b1;
    row_inc = {1'b0, cur_row} + 1'b1;
    col_nxt = col_inc[lpt_pkg::COL_W-1:0];
    row_nxt = cur_row;
    if (col_inc >= (lpt_pkg::COL_W+1)'(BYTES_PER_ROW)) begin
      col_nxt = '0;
      row_nxt = row_inc[lpt_pkg::ROW_W-1:0];
      if (row_inc >= (lpt_pkg::ROW_W+1)'(SCREEN_ROWS)) begin
        row_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (advance) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

FILE: src/lpt_emitter.sv
// Job slot, result sequencer and output register.
module lpt_emitter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          job_valid,
  input  lpt_pkg::job_t                 job,
  output logic                          job_ready,
  input  logic [lpt_pkg::STRIP_W-1:0]   rd_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_half_select,
  output logic                          out_is_data,
  output logic [7:0]                    out_bus_byte,
  output logic                          out_run_last
);

  // Job slot: waits here while the sequencer drains the previous item
  logic           s1_valid_r;
  lpt_pkg::job_t  s1_r;
  logic           s1_move;

  // Sequencer
  logic                      em_valid_r;
  logic [3:0]                step_r, last_r;
  logic                      half_r;
  logic [lpt_pkg::PAGE_W-1:0] page_r;
  logic [63:0]               trans_r;
  logic                      em_fire, em_last, em_free;

  // Output register
  logic       out_valid_r;
  logic       half_o_r, data_o_r, last_o_r;
  logic [7:0] byte_o_r;
  logic       out_free;

  // Next result fields
  logic       nx_half, nx_data;
  logic [7:0] nx_byte;
  logic [2:0] bit_sel;

  assign out_free  = !out_valid_r || !out_stall;
  assign em_fire   = em_valid_r && out_free;
  assign em_last   = (step_r == last_r);
  assign em_free   = !em_valid_r || (em_fire && em_last);
  assign s1_move   = s1_valid_r && em_free;
  assign job_ready = !s1_valid_r || em_free;

  // Job slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (job_ready) begin
      s1_valid_r <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (job_ready && job_valid) begin
      s1_r <= job;
    end
  end

  // Sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_valid_r <= 1'b0;
      step_r     <= lpt_pkg::STEP_PAIR_L;
    end else if (s1_move) begin
      em_valid_r <= 1'b1;
      if (s1_r.pair) begin
        step_r <= lpt_pkg::STEP_PAIR_L;
      end else if (s1_r.page_en) begin
        step_r <= lpt_pkg::STEP_PAGE;
      end else begin
        step_r <= lpt_pkg::STEP_DATA0;
      end
    end else if (em_fire) begin
      if (em_last) begin
        em_valid_r <= 1'b0;
      end
      step_r <= step_r + 1'b1;
    end
  end

  // Sequencer payload; memory read data lines up with the slot's job
  always_ff @(posedge clk) begin
    if (s1_move) begin
      last_r  <= s1_r.pair ? lpt_pkg::STEP_PAIR_R : lpt_pkg::STEP_DATA_LAST;
      half_r  <= s1_r.half;
      page_r  <= s1_r.page;
      trans_r <= lpt_pkg::transpose8({s1_r.pix, rd_data});
    end
  end

  // Fields of the result for the current step
  always_comb begin
    bit_sel = 3'(lpt_pkg::STEP_DATA_LAST - step_r);
    nx_half = half_r;
    nx_data = 1'b0;
    nx_byte = lpt_pkg::CMD_COL_RESET;
    case (step_r)
      lpt_pkg::STEP_PAIR_L: begin
        nx_half = 1'b0;
      end
      lpt_pkg::STEP_PAIR_R: begin
        nx_half = 1'b1;
      end
      lpt_pkg::STEP_PAGE: begin
        nx_byte = lpt_pkg::CMD_PAGE | {5'b0, page_r};
      end
      default: begin
        nx_data = 1'b1;
        nx_byte = trans_r[{bit_sel, 3'b000} +: 8];
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= em_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (em_fire) begin
      half_o_r <= nx_half;
      data_o_r <= nx_data;
      byte_o_r <= nx_byte;
      last_o_r <= em_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_half_select = half_o_r;
  assign out_is_data     = data_o_r;
  assign out_bus_byte    = byte_o_r;
  assign out_run_last    = last_o_r;

endmodule

FILE: src/lpt_checker.sv
// Port-level checks for the LCD page transpose feeder, bound to the top level.
module lpt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_half_select,
  input logic       out_is_data,
  input logic [7:0] out_bus_byte,
  input logic       out_run_last
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_bus_byte)
      && $stable(out_is_data) && $stable(out_half_select) && $stable(out_run_last))
    else $error("stalled result changed");

  // Only column-reset and page commands exist
  a_cmd_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_data |->
      (out_bus_byte == lpt_pkg::CMD_COL_RESET) ||
      (out_bus_byte[7:3] == lpt_pkg::CMD_PAGE[7:3]))
    else $error("unknown command byte");

  // Left column reset opens a run, right column reset closes it
  a_reset_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_data && (out_bus_byte == lpt_pkg::CMD_COL_RESET) |->
      (out_run_last == out_half_select))
    else $error("column reset pair out of order");

  // Page command is always followed by data of the same item
  a_page_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_data && (out_bus_byte[7:3] == lpt_pkg::CMD_PAGE[7:3])
      |-> !out_run_last)
    else $error("page command ends a run");

endmodule

bind lcd_page_transpose_feeder lpt_checker u_lpt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_half_select (out_half_select),
  .out_is_data     (out_is_data),
  .out_bus_byte    (out_bus_byte),
  .out_run_last    (out_run_last)
);

FILE: bench/lcd_page_transpose_feeder_tb.sv
// Self-checking testbench for the LCD page transpose feeder.
`timescale 1ns / 100ps

module lcd_page_transpose_feeder_tb;

  localparam int SCREEN_ROWS   = 64;
  localparam int BYTES_PER_ROW = 16;
  localparam int HALF_COLS     = BYTES_PER_ROW / 2;

  // One write on the panel bus
  typedef struct packed {
    logic       half;
    logic       is_data;
    logic [7:0] bus_byte;
    logic       last;
  } panel_write_t;

  // Predicts panel writes from accepted frame bytes and checks what comes out
  class panel_write_board;
    panel_write_t                    pending[$];
    logic [lpt_pkg::STRIP_W-1:0]     strip [lpt_pkg::STRIP_DEPTH];
    logic [lpt_pkg::STRIP_LANES-1:0] lanes_written [lpt_pkg::STRIP_DEPTH];
    int                              row_pos;
    int                              col_pos;
    int                              errors;

    function new();
      row_pos   = 0;
      col_pos   = 0;
      errors    = 0;
      foreach (lanes_written[i]) lanes_written[i] = '0;
    endfunction

    // Next byte would close a strip column whose upper rows were never stored
    function bit must_restart();
      return (row_pos % 8 == 7) && (lanes_written[col_pos] != '1);
    endfunction

    function void queue_write(logic half, logic is_data, logic [7:0] b);
      panel_write_t w;
      w = '{half, is_data, b, 1'b0};
      pending.push_back(w);
    endfunction

    function void note_input(logic [7:0] pix, logic frame_start);
      int           srow;
      int           first;
      logic         half;
      logic [63:0]  column;
      logic [7:0]   v;
      if (frame_start) begin
        row_pos = 0;
        col_pos = 0;
      end
      srow  = row_pos % 8;
      half  = (col_pos >= HALF_COLS);
      first = pending.size();
      // column-reset pair at the top-left position
      if (row_pos == 0 && col_pos == 0) begin
        queue_write(1'b0, 1'b0, lpt_pkg::CMD_COL_RESET);
        queue_write(1'b1, 1'b0, lpt_pkg::CMD_COL_RESET);
      end
      if (srow != 7) begin
        strip[col_pos][srow*8 +: 8] = pix;
        lanes_written[col_pos][srow] = 1'b1;
      end else begin
        column = {pix, strip[col_pos]};
        if (col_pos == 0 || col_pos == HALF_COLS)
          queue_write(half, 1'b0, lpt_pkg::CMD_PAGE | 8'(row_pos / 8));
        // leftmost pixel column first, bit k from strip row k
        for (int b = 7; b >= 0; b--) begin
          v = '0;
          for (int k = 0; k < 8; k++) v[k] = column[k*8 + b];
          queue_write(half, 1'b1, v);
        end
      end
      if (pending.size() > first) pending[pending.size()-1].last = 1'b1;
      // advance position
      col_pos++;
      if (col_pos >= BYTES_PER_ROW) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= SCREEN_ROWS) begin
          row_pos = 0;
        end
      end
    endfunction

    function void check_write(logic half, logic is_data, logic [7:0] b, logic last);
      panel_write_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected write: half %0d data %0d byte %02h last %0d",
                   half, is_data, b, last);
        return;
      end
      want = pending.pop_front();
      if (half !== want.half || is_data !== want.is_data ||
          b !== want.bus_byte || last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display("write mismatch: want h%0d d%0d %02h l%0d, got h%0d d%0d %02h l%0d",
                   want.half, want.is_data, want.bus_byte, want.last,
                   half, is_data, b, last);
      end
    endfunction
  endclass

  logic       clk            = 1'b0;
  logic       rst_n          = 1'b0;
  logic       in_valid       = 1'b0;
  logic [7:0] in_pixel_byte  = 8'h00;
  logic       in_frame_start = 1'b0;
  logic       out_stall      = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic       out_half_select;
  logic       out_is_data;
  logic [7:0] out_bus_byte;
  logic       out_run_last;

  panel_write_board sb;
  bit               sender_burst = 1'b0;
  logic [7:0]       corner [4] = '{8'h00, 8'hFF, 8'h80, 8'h01};

  lcd_page_transpose_feeder #(
    .SCREEN_ROWS  (SCREEN_ROWS),
    .BYTES_PER_ROW(BYTES_PER_ROW)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel_byte  (in_pixel_byte),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_half_select(out_half_select),
    .out_is_data    (out_is_data),
    .out_bus_byte   (out_bus_byte),
    .out_run_last   (out_run_last)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Offer one frame byte after a random gap, hold it until taken
  task automatic send_item(input logic [7:0] pix, input logic frame_start);
    int gap;
    if ($urandom_range(0, 19) == 0) sender_burst = !sender_burst;
    gap = sender_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel_byte  <= pix;
    in_frame_start <= frame_start;
    do @(posedge clk); while (in_stall);
    sb.note_input(pix, frame_start);
  endtask

  // Random byte; restarts the frame now and then, and whenever a strip
  // column would be closed before its upper rows were stored
  task automatic random_item(input int restart_odds);
    logic frame_start;
    frame_start = (restart_odds > 0 && $urandom_range(1, restart_odds) == 1) ||
                  sb.must_restart();
    send_item(8'($urandom_range(0, 255)), frame_start);
  endtask

  // Receiver: random stalls per item, bursts without stalls, one long hold-off
  initial begin : receiver
    int hold;
    int taken;
    bit burst;
    bit pressure_done;
    taken         = 0;
    burst         = 1'b0;
    pressure_done = 1'b0;
    forever begin
      if ($urandom_range(0, 24) == 0) burst = !burst;
      hold = burst ? 0 : $urandom_range(0, 9);
      if (!pressure_done && taken >= 100) begin
        hold          = 1200;
        pressure_done = 1'b1;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
      taken++;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_write(out_half_select, out_is_data, out_bus_byte, out_run_last);
  end

  // Stimulus and end of run
  initial begin : stimulus
    int spare;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: frame start, corner bytes across the half boundary and
    // into the next row, restart mid-row, back-to-back restarts
    send_item(8'hFF, 1'b1);
    for (int n = 0; n < 17; n++) send_item(corner[n % 4], 1'b0);
    send_item(8'hAA, 1'b1);
    send_item(8'h55, 1'b1);

    // broken sequences with frequent restarts
    repeat (100) random_item(12);

    // clean frame through the first two strips, page commands on both halves
    send_item(8'($urandom_range(0, 255)), 1'b1);
    repeat (255) random_item(0);

    // noise afterwards
    repeat (60) random_item(16);
    in_valid <= 1'b0;

    // drain
    spare = 0;
    while (sb.pending.size() != 0 && spare < 50000) begin
      @(posedge clk);
      spare++;
    end
    repeat (20) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $display("%0d expected writes never arrived", sb.pending.size());
      sb.errors += sb.pending.size();
    end

    if (sb.errors == 0)
      $display("** lcd_page_transpose_feeder: PASSED **");
    else
      $display("** lcd_page_transpose_feeder: FAILED **");
    $finish;
  end

  // Hang guard
  initial begin : watchdog
    #20_000_000;
    $display("** lcd_page_transpose_feeder: FAILED **");
    $finish;
  end

endmodule

FILE: sim.f
src/lpt_pkg.sv
src/lpt_strip_mem.sv
src/lpt_locator.sv
src/lpt_emitter.sv
src/lcd_page_transpose_feeder.sv
src/lpt_checker.sv
bench/lcd_page_transpose_feeder_tb.sv
